>>> rtl/core/bts_pkg.sv
// shared types and constants of the bilinear texture sampler
package bts_pkg;

  localparam int unsigned MaxSide    = 256;
  localparam int unsigned TexelDepth = 65536;
  localparam int unsigned SideW      = 9;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned IndexW     = 16;
  localparam int unsigned CoordW     = 32;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned ColorW     = 16;
  localparam int unsigned TexelW     = 3 * ChanW;
  localparam int unsigned CfgAddrW   = 3;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd4
  } reg_addr_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } texel_t;

endpackage

>>> rtl/core/bts_stream_if.sv
// valid-ready channel interfaces for sample requests and results
interface bts_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] u_coord;
  logic [31:0] v_coord;
  logic [15:0] texel_index;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  modport source (output valid, command, u_coord, v_coord, texel_index,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, command, u_coord, v_coord, texel_index,
                red_in, green_in, blue_in, output ready);
endinterface

interface bts_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_out;
  logic [15:0] green_out;
  logic [15:0] blue_out;
  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

>>> rtl/core/bts_ram.sv
// generic single-write two-read ram with registered read data
module bts_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end
endmodule

>>> rtl/core/bts_addr.sv
// coordinate stages: fraction scaling, neighbour wrap and texel addresses
module bts_addr (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic                       sample_i,
  input  logic [bts_pkg::SideW-1:0]  width_i,
  input  logic [bts_pkg::SideW-1:0]  height_i,
  input  logic [15:0]                fu_i,
  input  logic [15:0]                fv_i,
  output logic                       valid_o,
  output logic                       zero_o,
  output logic [7:0]                 wx_o,
  output logic [7:0]                 wy_o,
  output logic [bts_pkg::AddrW-1:0]  a00_o,
  output logic [bts_pkg::AddrW-1:0]  a10_o,
  output logic [bts_pkg::AddrW-1:0]  a01_o,
  output logic [bts_pkg::AddrW-1:0]  a11_o
);
  import bts_pkg::*;

  // stage 1: scale fractions
  logic              v1_q, z1_q;
  logic [SideW-1:0]  w1_q, h1_q;
  logic signed [26:0] x1_q, y1_q;
  logic [SideW-1:0]  w_c, h_c;
  logic [16:0]       fvf;

  assign w_c = (width_i > SideW'(MaxSide)) ? SideW'(MaxSide) : width_i;
  assign h_c = (height_i > SideW'(MaxSide)) ? SideW'(MaxSide) : height_i;
  assign fvf = 17'd65536 - {1'b0, fv_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i && sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q <= (w_c == '0) || (h_c == '0);
      w1_q <= w_c;
      h1_q <= h_c;
      x1_q <= $signed({2'b00, 25'({16'd0, fu_i} * {16'd0, w_c})}) - 27'sd32768;
      y1_q <= $signed({2'b00, 25'({8'd0, fvf} * {16'd0, h_c})}) - 27'sd32768;
    end
  end

  // stage 2: wrap indices; base is -1 .. side - 1
  logic              v2_q, z2_q;
  logic [SideW-1:0]  w2_q;
  logic [7:0]        wx2_q, wy2_q;
  logic [SideW-1:0]  x0_q, x1w_q, y0_q, y1w_q;
  logic signed [10:0] bx, by;
  logic [SideW-1:0]  x0_d, x1_d, y0_d, y1_d;

  assign bx = x1_q[26:16];
  assign by = y1_q[26:16];

  always_comb begin
    x0_d = (bx < 0) ? w1_q - 1'b1 : SideW'(bx);
    x1_d = (bx + 11'sd1 >= $signed({2'b00, w1_q})) ? '0 : SideW'(bx + 11'sd1);
    y0_d = (by < 0) ? h1_q - 1'b1 : SideW'(by);
    y1_d = (by + 11'sd1 >= $signed({2'b00, h1_q})) ? '0 : SideW'(by + 11'sd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z2_q  <= z1_q;
      w2_q  <= w1_q;
      wx2_q <= x1_q[15:8];
      wy2_q <= y1_q[15:8];
      x0_q  <= x0_d;
      x1w_q <= x1_d;
      y0_q  <= y0_d;
      y1w_q <= y1_d;
    end
  end

  // stage 3: row * width + column, modulo store depth
  logic [17:0] r0w, r1w;
  assign r0w = y0_q * w2_q;
  assign r1w = y1w_q * w2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_o <= z2_q;
      wx_o   <= wx2_q;
      wy_o   <= wy2_q;
      a00_o  <= AddrW'(r0w + 18'(x0_q));
      a10_o  <= AddrW'(r0w + 18'(x1w_q));
      a01_o  <= AddrW'(r1w + 18'(x0_q));
      a11_o  <= AddrW'(r1w + 18'(x1w_q));
    end
  end
endmodule

>>> rtl/core/bts_blend.sv
// blend stages: horizontal then vertical weighting of the four texels
module bts_blend (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic                         zero_i,
  input  logic [7:0]                   wx_i,
  input  logic [7:0]                   wy_i,
  input  bts_pkg::texel_t              c00_i,
  input  bts_pkg::texel_t              c10_i,
  input  bts_pkg::texel_t              c01_i,
  input  bts_pkg::texel_t              c11_i,
  output logic                         valid_o,
  output logic [3*bts_pkg::ColorW-1:0] color_o
);
  import bts_pkg::*;

  logic [2:0][ChanW-1:0] p00, p10, p01, p11;
  assign p00 = c00_i;
  assign p10 = c10_i;
  assign p01 = c01_i;
  assign p11 = c11_i;

  logic        v1_q, z1_q;
  logic [7:0]  wy1_q;
  logic [2:0][15:0] r0_q, r1_q;
  logic [8:0]  iwx;
  assign iwx = 9'd256 - {1'b0, wx_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      valid_o <= v1_q;
    end
  end

  logic [8:0] iwy;
  assign iwy = 9'd256 - {1'b0, wy1_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z1_q  <= zero_i;
      wy1_q <= wy_i;
      for (int k = 0; k < 3; k++) begin
        r0_q[k] <= 16'(p00[k] * iwx) + 16'(p10[k] * wx_i);
        r1_q[k] <= 16'(p01[k] * iwx) + 16'(p11[k] * wx_i);
      end
      for (int k = 0; k < 3; k++) begin
        color_o[k*ColorW +: ColorW] <= z1_q ? '0 :
          ColorW'((25'(r0_q[k] * iwy) + 25'(r1_q[k] * wy1_q)) >> 8);
      end
    end
  end
endmodule

>>> rtl/core/bilinear_texture_sampler_unit.sv
// top level of the bilinear texture sampler with repeat wrap
// a sample beat passes six register stages from acceptance to its result
// throughput: one beat per cycle while not stalled; a texel write is one beat, no result
// the store is split four ways by the low address bits, each bank kept twice with
// two read ports per copy, so the four neighbours are read in the same cycle
// reset clears all valid bits and both size registers; the store needs no clearing pass
module bilinear_texture_sampler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bts_req_if.sink              req,
  bts_rsp_if.source            rsp,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [bts_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bts_pkg::*;

  localparam int unsigned BankDepth = (TexelDepth + 3) / 4;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;

  // config registers
  logic [SideW-1:0] width_q, height_q;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_addr_e'(paddr))
        REG_WIDTH:  width_q  <= pwdata[SideW-1:0];
        REG_HEIGHT: height_q <= pwdata[SideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_addr_e'(paddr))
      REG_WIDTH:  prdata = {23'd0, width_q};
      REG_HEIGHT: prdata = {23'd0, height_q};
      default:    prdata = '0;
    endcase
  end

  // pipeline advances unless the output register holds an untaken beat
  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  logic acc;
  assign acc = req.valid && req.ready;

  logic wr_en;
  assign wr_en = acc && (cmd_e'(req.command) == CMD_WRITE)
                 && (32'(req.texel_index) < TexelDepth);

  // texel writes ride three stages beside the address stages, so they reach
  // the store in beat order relative to the sample reads
  logic [2:0]        wv_q;
  logic [IndexW-1:0] widx_q [3];
  texel_t            wtex_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wv_q <= '0;
    end else if (en) begin
      wv_q <= {wv_q[1:0], wr_en};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      widx_q[0] <= req.texel_index;
      wtex_q[0] <= texel_t'({req.red_in, req.green_in, req.blue_in});
      for (int s = 1; s < 3; s++) begin
        widx_q[s] <= widx_q[s-1];
        wtex_q[s] <= wtex_q[s-1];
      end
    end
  end

  logic        av;
  logic        az;
  logic [7:0]  awx, awy;
  logic [AddrW-1:0] a00, a10, a01, a11;

  bts_addr u_addr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (acc),
    .sample_i (cmd_e'(req.command) == CMD_SAMPLE),
    .width_i  (width_q),
    .height_i (height_q),
    .fu_i     (req.u_coord[15:0]),
    .fv_i     (req.v_coord[15:0]),
    .valid_o  (av),
    .zero_o   (az),
    .wx_o     (awx),
    .wy_o     (awy),
    .a00_o    (a00),
    .a10_o    (a10),
    .a01_o    (a01),
    .a11_o    (a11)
  );

  // banking by address mod 4: the four neighbours of one sample need not
  // fall in distinct banks (depending on the width), so each bank has two read ports and
  // is replicated: copy 0 serves a00/a10, copy 1 serves a01/a11
  logic [AddrW-1:0] ra [4];
  assign ra[0] = a00;
  assign ra[1] = a10;
  assign ra[2] = a01;
  assign ra[3] = a11;

  texel_t rd [4][4];
  logic [1:0] sel_q [4];
  logic rv_q, rz_q;
  logic [7:0] rwx_q, rwy_q;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [BankAw-1:0] waddr;
    assign waddr = BankAw'(widx_q[2] >> 2);
    for (genvar c = 0; c < 2; c++) begin : g_copy
      logic [TexelW-1:0] da, db;
      bts_ram #(.Width(TexelW), .Depth(BankDepth)) u_ram (
        .clk_i     (clk_i),
        .we_i      (en && wv_q[2] && (widx_q[2][1:0] == 2'(b))),
        .waddr_i   (waddr),
        .wdata_i   (wtex_q[2]),
        .re_i      (en),
        .raddr_a_i (BankAw'(ra[2*c] >> 2)),
        .raddr_b_i (BankAw'(ra[2*c+1] >> 2)),
        .rdata_a_o (da),
        .rdata_b_o (db)
      );
      assign rd[b][2*c]   = texel_t'(da);
      assign rd[b][2*c+1] = texel_t'(db);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= av;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rz_q  <= az;
      rwx_q <= awx;
      rwy_q <= awy;
      for (int n = 0; n < 4; n++) begin
        sel_q[n] <= ra[n][1:0];
      end
    end
  end

  // bank select per neighbour after the registered read
  texel_t tx [4];
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      tx[n] = rd[sel_q[n]][n];
    end
  end

  logic bv;
  logic [3*ColorW-1:0] color;

  bts_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rv_q),
    .zero_i  (rz_q),
    .wx_i    (rwx_q),
    .wy_i    (rwy_q),
    .c00_i   (tx[0]),
    .c10_i   (tx[1]),
    .c01_i   (tx[2]),
    .c11_i   (tx[3]),
    .valid_o (bv),
    .color_o (color)
  );

  // blend output doubles as the output register
  assign rsp.valid     = bv;
  assign rsp.blue_out  = color[0 +: ColorW];
  assign rsp.green_out = color[ColorW +: ColorW];
  assign rsp.red_out   = color[2*ColorW +: ColorW];
endmodule

>>> rtl/core/bts_checker.sv
// port-level checker for the texture sampler, bound to the top level
module bts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] red_out,
  input logic [15:0] green_out,
  input logic [15:0] blue_out,
  input logic        pready
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(red_out)
      && $stable(green_out) && $stable(blue_out))
    else $error("result beat changed while stalled");

  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid |-> req_ready)
    else $error("input stalled with empty output");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> red_out <= 16'd65280 && green_out <= 16'd65280
      && blue_out <= 16'd65280)
    else $error("color out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");
endmodule

bind bilinear_texture_sampler_unit bts_checker u_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .red_out   (rsp.red_out),
  .green_out (rsp.green_out),
  .blue_out  (rsp.blue_out),
  .pready    (pready)
);

>>> tb/bilinear_texture_sampler_unit_test.sv
// testbench for the bilinear texture sampler: random loads and samples against a predictor
`timescale 1ns / 100ps

module bilinear_texture_sampler_unit_test;
  import bts_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 300;

  logic clk;
  logic rst_n;

  bts_req_if req_bus ();
  bts_rsp_if rsp_bus ();

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // sampler shadow: its own texel store and size registers
  class texture_scoreboard;
    bit [TexelW-1:0] texels [TexelDepth];
    bit [SideW-1:0]  width_reg;
    bit [SideW-1:0]  height_reg;
    bit [3*ColorW-1:0] color_q [$];

    function longint side(bit [SideW-1:0] r);
      return (r > MaxSide) ? MaxSide : r;
    endfunction

    function longint wrap(longint i, longint n);
      longint r;
      r = i % n;
      if (r < 0) r += n;
      return r;
    endfunction

    function bit [3*ColorW-1:0] blend(bit [31:0] u, bit [31:0] v);
      longint w, h, x, y, x0, x1, y0, y1;
      int unsigned wx, wy, r0, r1, val;
      bit [TexelW-1:0] c00, c10, c01, c11;
      bit [3*ColorW-1:0] res;
      w = side(width_reg);
      h = side(height_reg);
      if (w == 0 || h == 0) return '0;
      x = longint'(u[15:0]) * w - 32768;
      y = (65536 - longint'(v[15:0])) * h - 32768;
      wx = x[15:8];
      wy = y[15:8];
      // arithmetic shift is a floor, negative positions included
      x0 = wrap(x >>> 16, w);
      x1 = wrap((x >>> 16) + 1, w);
      y0 = wrap(y >>> 16, h);
      y1 = wrap((y >>> 16) + 1, h);
      c00 = texels[(y0 * w + x0) % TexelDepth];
      c10 = texels[(y0 * w + x1) % TexelDepth];
      c01 = texels[(y1 * w + x0) % TexelDepth];
      c11 = texels[(y1 * w + x1) % TexelDepth];
      for (int k = 0; k < 3; k++) begin
        r0 = c00[16-8*k +: 8] * (256 - wx) + c10[16-8*k +: 8] * wx;
        r1 = c01[16-8*k +: 8] * (256 - wx) + c11[16-8*k +: 8] * wx;
        val = (r0 * (256 - wy) + r1 * wy) >> 8;
        res[32-16*k +: 16] = val[15:0];
      end
      return res;
    endfunction

    function void note_beat(bit cmd, bit [31:0] u, bit [31:0] v, bit [15:0] idx,
                            bit [7:0] r, bit [7:0] g, bit [7:0] b);
      if (cmd == CMD_WRITE) texels[idx] = {r, g, b};
      else color_q.push_back(blend(u, v));
    endfunction

    // returns a mask of wrong fields (red, green, blue) and the expected color
    function bit [2:0] check_color(logic [3*ColorW-1:0] got,
                                   output bit [3*ColorW-1:0] want);
      bit [2:0] bad;
      want = color_q.pop_front();
      for (int k = 0; k < 3; k++)
        bad[2-k] = (got[32-16*k +: 16] !== want[32-16*k +: 16]);
      return bad;
    endfunction
  endclass

  texture_scoreboard sb;
  bit written [TexelDepth];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit idle_on;
  bit hold_req;

  bilinear_texture_sampler_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // result side: compare every result beat against the oldest predicted color
  always @(posedge clk) begin
    bit [2:0] bad;
    bit [3*ColorW-1:0] want;
    string names [3];
    logic [3*ColorW-1:0] got;
    names = '{"red", "green", "blue"};
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      got = {rsp_bus.red_out, rsp_bus.green_out, rsp_bus.blue_out};
      if (sb.color_q.size() == 0) begin
        report($sformatf("result beat with nothing expected, color %h", got));
      end else begin
        bad = sb.check_color(got, want);
        for (int k = 0; k < 3; k++)
          if (bad[2-k])
            report($sformatf("%s got %h want %h", names[k], got[32-16*k +: 16],
                             want[32-16*k +: 16]));
      end
    end
  end

  // result ready: random short bursts of back-pressure while idle_on is set, or one long hold on request
  initial begin
    int unsigned burst;
    int unsigned hold;
    burst = 0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold = LongHold;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        rsp_bus.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 4);
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no beat on any side ends the run
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("bilinear_texture_sampler_unit_test failed");
      $finish;
    end
  end

  // one request beat, with an optional random gap in front of it
  task automatic send_beat(bit cmd, bit [31:0] u, bit [31:0] v, bit [15:0] idx,
                           bit [7:0] r, bit [7:0] g, bit [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_bus.valid       <= 1'b1;
    req_bus.command     <= cmd;
    req_bus.u_coord     <= u;
    req_bus.v_coord     <= v;
    req_bus.texel_index <= idx;
    req_bus.red_in      <= r;
    req_bus.green_in    <= g;
    req_bus.blue_in     <= b;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_beat(cmd, u, v, idx, r, g, b);
    if (cmd == CMD_WRITE) written[idx] = 1'b1;
  endtask

  task automatic load_texel(bit [15:0] idx);
    bit [23:0] c;
    c = 24'($urandom);
    // extremes now and then so each channel sees 00 and ff
    case ($urandom_range(0, 7))
      0: c = '0;
      1: c = '1;
      default: ;
    endcase
    send_beat(CMD_WRITE, $urandom, $urandom, idx, c[23:16], c[15:8], c[7:0]);
  endtask

  task automatic sample(bit [31:0] u, bit [31:0] v);
    send_beat(CMD_SAMPLE, u, v, 16'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  // wait for every predicted color, then cover the pipeline latency of trailing writes
  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (sb.color_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apb_write(logic [CfgAddrW-1:0] addr, bit [SideW-1:0] value);
    bit [31:0] data;
    data = $urandom;
    data[SideW-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == REG_WIDTH) sb.width_reg = value;
    else sb.height_reg = value;
  endtask

  // set the texture size, then load every texel a sample at this size can reach
  task automatic resize(int unsigned w, int unsigned h);
    drain();
    apb_write(REG_WIDTH, SideW'(w));
    apb_write(REG_HEIGHT, SideW'(h));
    for (int unsigned a = 0; a < w * h; a++)
      if (!written[a]) load_texel(16'(a));
  endtask

  task automatic sample_extremes();
    bit [31:0] pts [6];
    pts = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_8000,
            32'h0001_0080};
    foreach (pts[i]) sample(pts[i], pts[5-i]);
  endtask

  initial begin
    int unsigned ws [8];
    int unsigned hs [8];
    sb = new();
    mismatches = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_bus.valid = 1'b0;
    req_bus.command = CMD_WRITE;
    req_bus.u_coord = '0;
    req_bus.v_coord = '0;
    req_bus.texel_index = '0;
    req_bus.red_in = '0;
    req_bus.green_in = '0;
    req_bus.blue_in = '0;
    rsp_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sizes are zero after reset: samples give black whatever the store holds
    send_beat(CMD_WRITE, '1, '1, 16'hffff, 8'hff, 8'h00, 8'hff);
    sample_extremes();

    // one-texel texture: every neighbour is the same texel
    resize(1, 1);
    sample_extremes();

    // full-width single row, which loads the first 256 texels
    resize(MaxSide, 1);
    sample_extremes();

    // one side zero disables sampling either way
    resize(0, 5);
    sample(32'h1234_5678, 32'h9abc_def0);
    resize(5, 0);
    sample(32'h1234_5678, 32'h9abc_def0);

    // random phases: mostly samples, some texel reloads anywhere in the store;
    // an oversized width register is used as the full side
    ws = '{3, 256, 1, 300, 0, 17, 0, 7};
    hs = '{5, 1, 256, 1, 0, 3, 0, 9};
    for (int p = 0; p < 8; p++) begin
      if (ws[p] == 0) ws[p] = $urandom_range(1, 12);
      if (hs[p] == 0) hs[p] = $urandom_range(1, 12);
      resize(ws[p], hs[p]);
      if (p == 7) idle_on = 1'b0;
      for (int i = 0; i < 48; i++) begin
        if (p == 2 && i == 10) hold_req = 1'b1;
        if ($urandom_range(0, 4) == 0) load_texel(16'($urandom));
        else sample($urandom, $urandom);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("bilinear_texture_sampler_unit_test passed");
    end else begin
      $display("bilinear_texture_sampler_unit_test failed");
    end
    $finish;
  end

endmodule
